### hw/rtl/pwmb_pkg.sv
// ----------------------------------------------------------------------------
// pwmb_pkg
// Types, constants and the wave table of the pseudo-sine PWM beeper.
// ----------------------------------------------------------------------------
package pwmb_pkg;

    localparam int MUL_W   = 16;              // serial multiplier operand width
    localparam int DVD_W   = 35;              // serial divider dividend width
    localparam int DVS_W   = 16;              // serial divider divisor width
    localparam int STEP_W  = 26;              // note step counters
    localparam int STAGE_W = 3;               // wave stage, eight steps
    localparam int PRE_W   = 5;               // prescaler count while halving
    localparam int PROD_W  = 26;              // gain times period
    localparam int NUM_W   = 29;              // duty numerator magnitude

    localparam logic [15:0] PAUSE_PERIOD = 16'd42000;
    localparam logic [15:0] STEP_DIV     = 16'd1000;
    localparam logic [9:0]  GAIN_RST     = 10'd384;
    localparam logic [15:0] PERIOD_RST   = 16'd875;

    localparam logic [1:0] CFG_SOUND_ENABLE = 2'd0;
    localparam logic [1:0] CFG_GAIN         = 2'd1;
    localparam logic [1:0] CFG_PERIOD       = 2'd2;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] tone_hz;
        logic [15:0] duration_ms;
    } t_in;

    typedef struct packed {
        logic [15:0] duty;
        logic        duty_valid;
        logic        timer_start;
        logic        one_pulse;
        logic [15:0] timer_prescaler;
        logic [15:0] timer_period;
        logic        timer_stop;
        logic        note_done;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_HALVE,
        ST_DIV_S,
        ST_DUTY,
        ST_EMIT
    } t_state;

    // doubled wave value of each stage: 0 1 2 1 0 -1 -2 -1
    function automatic logic signed [2:0] wave_val(input logic [STAGE_W-1:0] stage);
        logic signed [2:0] v;
        case (stage)
            3'd1, 3'd3: v = 3'sd1;
            3'd2:       v = 3'sd2;
            3'd5, 3'd7: v = -3'sd1;
            3'd6:       v = -3'sd2;
            default:    v = 3'sd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/pwm_pseudo_sine_beeper.sv
// ----------------------------------------------------------------------------
// pwm_pseudo_sine_beeper
// Tone beeper: sets up the tick timer per note and emits pseudo-sine duty.
// ----------------------------------------------------------------------------
// Path from accept to output register: an ignored start, a pause start or
// an idle tick go straight to the emit state; a running tick first waits for
// the serial multiply; a tone start runs two serial divides and a halving
// step per period halving. One item in flight; the next beat is taken once
// the result sits in the output register. Reset restores register defaults
// and clears step counters, stage and out valid.
// ----------------------------------------------------------------------------
module pwm_pseudo_sine_beeper #(
    parameter int TONE_CLOCK = 10500000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pwmb_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pwmb_pkg::t_out   o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_wdata
);
    import pwmb_pkg::*;

    localparam int PER_W = $clog2(TONE_CLOCK + 1);

    t_state              r_state, n_state;
    logic                r_en;
    logic [9:0]          r_gain;
    logic [15:0]         r_period;
    logic [STEP_W-1:0]   r_pending, n_pending;
    logic [STEP_W-1:0]   r_left, n_left;
    logic [STAGE_W-1:0]  r_stage, n_stage;
    logic [PER_W-1:0]    r_per, n_per;
    logic [PRE_W-1:0]    r_presc, n_presc;
    t_out                r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                mul_start, mul_done;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    logic                div_start, div_done;
    logic [DVD_W-1:0]    div_dvd, div_q;
    logic [DVS_W-1:0]    div_dvs;
    logic                accept;

    logic signed [2:0]   wv;
    logic [PROD_W-1:0]   prod;
    logic [NUM_W-1:0]    term, base, num;
    logic                neg_clip;
    logic [NUM_W-11:0]   quo;
    logic [15:0]         duty;

    pwmb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    pwmb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // duty = clamp((v*g*P + 512*P) / 1024, 0, P)
    always_comb begin
        wv   = wave_val(r_stage);
        prod = mul_p[PROD_W-1:0];
        base = {4'b0, r_period, 9'b0};
        if (wv == 3'sd0) begin
            term = '0;
        end else if (wv == 3'sd2 || wv == -3'sd2) begin
            term = {2'b0, prod, 1'b0};
        end else begin
            term = {3'b0, prod};
        end
        neg_clip = 1'b0;
        if (wv < 0) begin
            neg_clip = term > base;
            num      = base - term;
        end else begin
            num = base + term;
        end
        quo = num[NUM_W-1:10];
        if (neg_clip) begin
            duty = '0;
        end else if (quo > {3'b0, r_period}) begin
            duty = r_period;
        end else begin
            duty = quo[15:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_left      = r_left;
        n_stage     = r_stage;
        n_per       = r_per;
        n_presc     = r_presc;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        mul_a       = i_in_data.duration_ms;
        mul_b       = i_in_data.tone_hz;
        div_dvd     = DVD_W'(TONE_CLOCK);
        div_dvs     = i_in_data.tone_hz;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (i_in_data.func == FUNC_START) begin
                        if (!r_en || i_in_data.duration_ms == '0) begin
                            n_state = ST_EMIT;
                        end else if (i_in_data.tone_hz == '0) begin
                            n_pending             = '0;
                            n_res.timer_start     = 1'b1;
                            n_res.one_pulse       = 1'b1;
                            n_res.timer_prescaler = {i_in_data.duration_ms[14:0], 1'b0};
                            n_res.timer_period    = PAUSE_PERIOD;
                            n_state               = ST_EMIT;
                        end else begin
                            mul_start = 1'b1;
                            div_start = 1'b1;
                            n_presc   = PRE_W'(1);
                            n_state   = ST_DIV_T;
                        end
                    end else begin
                        if (r_left == '0) begin
                            n_left           = r_pending;
                            n_pending        = '0;
                            n_res.timer_stop = (r_pending == '0);
                            n_res.note_done  = (r_pending == '0);
                            n_state          = ST_EMIT;
                        end else begin
                            mul_a     = {6'b0, r_gain};
                            mul_b     = r_period;
                            mul_start = 1'b1;
                            n_state   = ST_DUTY;
                        end
                    end
                end
            end
            ST_DIV_T: begin
                if (div_done) begin
                    n_per   = div_q[PER_W-1:0];
                    n_state = ST_HALVE;
                end
            end
            ST_HALVE: begin
                if (r_per[PER_W-1:16] != '0) begin
                    n_per   = r_per >> 1;
                    n_presc = r_presc + 1'b1;
                end else begin
                    div_dvd   = {mul_p, 3'b000};
                    div_dvs   = STEP_DIV;
                    div_start = 1'b1;
                    n_state   = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                if (div_done) begin
                    n_pending             = div_q[STEP_W-1:0];
                    n_res.timer_start     = 1'b1;
                    n_res.timer_prescaler = 16'(r_presc);
                    n_res.timer_period    = r_per[15:0];
                    n_state               = ST_EMIT;
                end
            end
            ST_DUTY: begin
                if (mul_done) begin
                    n_res.duty       = r_en ? duty : 16'd0;
                    n_res.duty_valid = r_en;
                    n_stage          = r_stage + 1'b1;
                    n_left           = r_left - 1'b1;
                    n_state          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b0;
            r_gain      <= GAIN_RST;
            r_period    <= PERIOD_RST;
            r_pending   <= '0;
            r_left      <= '0;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_left      <= n_left;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_SOUND_ENABLE: r_en     <= i_cfg_wdata[0];
                    CFG_GAIN:         r_gain   <= i_cfg_wdata[9:0];
                    CFG_PERIOD:       r_period <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_per   <= n_per;
        r_presc <= n_presc;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.duty_valid) |-> (o_out_data.duty <= r_period))
        else $error("duty above pwm period");

    a_start_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.timer_start && o_out_data.timer_stop))
        else $error("timer start and stop in one beat");

endmodule

### hw/rtl/pwmb_mul.sv
// ----------------------------------------------------------------------------
// pwmb_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pwmb_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pwmb_pkg::MUL_W-1:0]    i_a,
    input  logic [pwmb_pkg::MUL_W-1:0]    i_b,
    output logic                          o_done,
    output logic [2*pwmb_pkg::MUL_W-1:0]  o_prod
);
    import pwmb_pkg::*;

    localparam int CNT_W = $clog2(MUL_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [2*MUL_W-1:0]   r_a, n_a;
    logic [MUL_W-1:0]     r_b, n_b;
    logic [2*MUL_W-1:0]   r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = {{MUL_W{1'b0}}, i_a};
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = {r_a[2*MUL_W-2:0], 1'b0};
            n_b   = {1'b0, r_b[MUL_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MUL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hw/rtl/pwmb_div.sv
// ----------------------------------------------------------------------------
// pwmb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmb_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pwmb_pkg::DVD_W-1:0]  i_dividend,
    input  logic [pwmb_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pwmb_pkg::DVD_W-1:0]  o_quot
);
    import pwmb_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DVS_W-1:0]   r_rem, n_rem;
    logic [DVS_W-1:0]   r_dvs, n_dvs;
    logic [DVD_W-1:0]   r_quo, n_quo;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
